### src/drta_pkg.sv
// Shared types, register indexes and calendar helpers for the DST rule adjuster.
// Depends on nothing; imported by dst_rule_time_adjust.
package drta_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_START_MONTH = 3'd0;
	localparam logic [2:0] REG_START_WEEK  = 3'd1;
	localparam logic [2:0] REG_START_WDAY  = 3'd2;
	localparam logic [2:0] REG_START_HOUR  = 3'd3;
	localparam logic [2:0] REG_END_MONTH   = 3'd4;
	localparam logic [2:0] REG_END_WEEK    = 3'd5;
	localparam logic [2:0] REG_END_WDAY    = 3'd6;
	localparam logic [2:0] REG_END_HOUR    = 3'd7;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int CFG_W   = 5;

	// Reciprocal constants: x / 100 = (x * 5243) >> 19 for x < 43699,
	// x / 7 = (x * 9363) >> 16 for x < 13107.
	localparam logic [13:0] DIV100_MUL = 14'd5243;
	localparam int          DIV100_SH  = 19;
	localparam logic [13:0] DIV7_MUL   = 14'd9363;
	localparam int          DIV7_SH    = 16;

	localparam int MUL_A_W = 15;
	localparam int MUL_B_W = 14;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	typedef logic [MUL_A_W-1:0] mul_a_t;
	typedef logic [PROD_W-1:0]  prod_t;

	// Days in month; zero for codes that are no month
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// Month term of the weekday formula, floor(26 * (mm + 1) / 10)
	function automatic logic [5:0] month_term(input logic [4:0] mm);
		logic [5:0] t;
		case (mm)
			5'd3:    t = 6'd10;
			5'd4:    t = 6'd13;
			5'd5:    t = 6'd15;
			5'd6:    t = 6'd18;
			5'd7:    t = 6'd20;
			5'd8:    t = 6'd23;
			5'd9:    t = 6'd26;
			5'd10:   t = 6'd28;
			5'd11:   t = 6'd31;
			5'd12:   t = 6'd33;
			5'd13:   t = 6'd36;
			5'd14:   t = 6'd39;
			5'd15:   t = 6'd41;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

endpackage

### src/dst_rule_time_adjust.sv
// Daylight saving adjuster: nth-weekday start/end rules, one hour advance with carry.
// Depends on drta_pkg (types, register indexes, month length and weekday tables).
//
// Channel   Dir  Handshake              Content
// s_*       in   s_tvalid / s_tready    standard-time year, month, day, hour
// m_*       out  m_tvalid / m_tready    active flag and adjusted year, month, day, hour
// cfg_*     in   cfg_we (no wait)       start and end rule registers, index 0..7
//
// After its transfer an item passes through the sequencer to the result register: one
// shared 15x14 multiplier does the divisions by 100 and by 7 in ST_MULY, ST_LEAP and
// ST_MUL7, then the rule day advances by a week per cycle (at most four steps).
// s_tready is high only while the sequencer is idle; it is high again while a result
// waits, the next result being held back until the output register is free.
// arst_n clears the sequencer, the output valid and loads the default US rules.
module dst_rule_time_adjust (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // year_in[13:0], month_in[17:14], day_in[22:18], hour_in[27:23]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // dst_active[0], year_out[14:1], month_out[18:15],
	                               // day_out[23:19], hour_out[28:24]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [drta_pkg::CFG_W-1:0] cfg_data
);
	import drta_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MULY, ST_LEAP, ST_SUM, ST_MUL7, ST_MOD, ST_STEP, ST_DECIDE
	} state_t;

	state_t state_q;

	// Rule registers
	logic [3:0] start_month_q, end_month_q;
	logic [2:0] start_week_q, end_week_q, start_wday_q, end_wday_q;
	logic [4:0] start_hour_q, end_hour_q;

	// Captured item
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic [HOUR_W-1:0]  hour_q;

	// Selected rule for this item
	logic       need_q;
	logic [3:0] rmonth_q;
	logic [2:0] rsel_q, rwday_q;

	// Sequencer datapath
	prod_t       prod_q;
	logic        leap_q;
	logic [10:0] sum_q;
	logic [4:0]  rday_q;
	logic [2:0]  k_q;

	// Result register
	logic                out_valid_q, act_q;
	logic [YEAR_W-1:0]   yo_q;
	logic [MONTH_W-1:0]  mo_q;
	logic [DAY_W-1:0]    do_q;
	logic [HOUR_W-1:0]   ho_q;

	// Input unpack
	logic [YEAR_W-1:0]  in_year;
	logic [MONTH_W-1:0] in_month;
	logic [DAY_W-1:0]   in_day;
	logic [HOUR_W-1:0]  in_hour;

	assign in_year  = s_tdata[13:0];
	assign in_month = s_tdata[17:14];
	assign in_day   = s_tdata[22:18];
	assign in_hour  = s_tdata[27:23];

	// Rule selection at the transfer: at most one rule date is ever needed
	logic       in_season;
	logic [4:0] in_month_p1;
	logic       sel_eve, sel_start, sel_end;

	assign in_month_p1 = {1'b0, in_month} + 5'd1;
	assign in_season   = (in_month > start_month_q) && (in_month < end_month_q);
	assign sel_eve     = in_season && (in_month_p1 == {1'b0, end_month_q}) && (end_hour_q == '0);
	assign sel_start   = !in_season && (in_month == start_month_q);
	assign sel_end     = !in_season && !sel_start && (in_month == end_month_q);

	// Shared multiplier operands
	mul_a_t      mul_a;
	logic [13:0] mul_b;
	logic [14:0] full_year;
	logic        early_month;

	assign early_month = (rmonth_q < 4'd3);
	assign full_year   = {1'b0, year_q} + 15'd400 - {14'd0, early_month};

	always_comb begin
		mul_a = {1'b0, year_q};
		mul_b = DIV100_MUL;
		case (state_q)
			ST_LEAP: mul_a = full_year;
			ST_MUL7: begin
				mul_a = {4'd0, sum_q};
				mul_b = DIV7_MUL;
			end
			default: ;
		endcase
	end

	// Leap year from year / 100 (first product)
	logic [7:0]  cent;
	logic [14:0] rem100;
	logic        leap_now;

	assign cent     = prod_q[DIV100_SH +: 8];
	assign rem100   = {1'b0, year_q} - 15'(cent * 7'd100);
	assign leap_now = ((year_q[1:0] == 2'd0) && (rem100 != '0))
		|| ((rem100 == '0) && (cent[1:0] == 2'd0));

	// Weekday sum from full_year / 100 (second product)
	logic [14:0] yy_full;
	logic [6:0]  yy;
	logic [4:0]  mm;
	logic [10:0] wsum;

	assign yy_full = full_year - 15'(cent * 7'd100);
	assign yy      = yy_full[6:0];
	assign mm      = early_month ? ({1'b0, rmonth_q} + 5'd12) : {1'b0, rmonth_q};
	assign wsum    = 11'(yy) + 11'(yy[6:2]) + 11'(cent[7:2]) + 11'(cent * 3'd5)
		+ 11'(month_term(mm));

	// Weekday of the first, then offset of the first wanted weekday
	logic [7:0]  q7;
	logic [10:0] w1_full;
	logic [2:0]  w1;
	logic [3:0]  wd_diff, wd_off;

	assign q7      = prod_q[DIV7_SH +: 8];
	assign w1_full = sum_q - 11'(q7 * 3'd7);
	assign w1      = w1_full[2:0];
	assign wd_diff = {1'b0, rwday_q} + 4'd7 - {1'b0, w1};
	assign wd_off  = (wd_diff >= 4'd7) ? (wd_diff - 4'd7) : wd_diff;

	// Week stepping
	logic [4:0] len_rule, len_mon;
	logic [5:0] rday_p7;
	logic       step_done;

	assign len_rule  = month_len(rmonth_q, leap_q);
	assign len_mon   = month_len(month_q, leap_q);
	assign rday_p7   = {1'b0, rday_q} + 6'd7;
	assign step_done = (k_q == rsel_q) || (rday_p7 > {1'b0, len_rule});

	// Decision and carry
	logic       on;
	logic [5:0] day_p1, hour_p1;
	logic [4:0] month_p1;
	logic       out_free;
	logic       load_out;

	assign day_p1   = {1'b0, day_q} + 6'd1;
	assign hour_p1  = {1'b0, hour_q} + 6'd1;
	assign month_p1 = {1'b0, month_q} + 5'd1;
	assign out_free = !out_valid_q || m_tready;
	assign load_out = (state_q == ST_DECIDE) && out_free;

	always_comb begin
		on = 1'b0;
		if ((month_q > start_month_q) && (month_q < end_month_q)) begin
			on = 1'b1;
			// midnight end on the first: last hour of the month before is standard time
			if (need_q && (rday_q == 5'd1) && (day_q == len_mon) && (hour_q == 5'd23))
				on = 1'b0;
		end else if (month_q == start_month_q) begin
			on = (day_q > rday_q) || ((day_q == rday_q) && (hour_q >= start_hour_q));
		end else if (month_q == end_month_q) begin
			if (day_q < rday_q)
				on = !((day_p1 == {1'b0, rday_q}) && (end_hour_q == '0) && (hour_q == 5'd23));
			else if (day_q == rday_q)
				on = (hour_p1 < {1'b0, end_hour_q});
		end
	end

	// Adjusted time: advance the hour and carry into day, month and year
	logic [YEAR_W-1:0]  adj_year;
	logic [MONTH_W-1:0] adj_month;
	logic [DAY_W-1:0]   adj_day;
	logic [HOUR_W-1:0]  adj_hour;

	always_comb begin
		adj_year  = year_q;
		adj_month = month_q;
		adj_day   = day_q;
		adj_hour  = hour_q;
		if (on) begin
			if (hour_q == 5'd23) begin
				adj_hour = '0;
				adj_day  = day_p1[4:0];
				if ((len_mon != '0) && (day_p1 > {1'b0, len_mon})) begin
					adj_day = 5'd1;
					if (month_q == 4'd12) begin
						adj_month = 4'd1;
						adj_year  = year_q + 14'd1;
					end else begin
						adj_month = month_p1[3:0];
					end
				end
			end else begin
				adj_hour = hour_p1[4:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			start_month_q <= 4'd3;
			start_week_q  <= 3'd2;
			start_wday_q  <= 3'd0;
			start_hour_q  <= 5'd2;
			end_month_q   <= 4'd11;
			end_week_q    <= 3'd1;
			end_wday_q    <= 3'd0;
			end_hour_q    <= 5'd2;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_START_MONTH: start_month_q <= cfg_data[3:0];
					REG_START_WEEK:  start_week_q  <= cfg_data[2:0];
					REG_START_WDAY:  start_wday_q  <= cfg_data[2:0];
					REG_START_HOUR:  start_hour_q  <= cfg_data;
					REG_END_MONTH:   end_month_q   <= cfg_data[3:0];
					REG_END_WEEK:    end_week_q    <= cfg_data[2:0];
					REG_END_WDAY:    end_wday_q    <= cfg_data[2:0];
					REG_END_HOUR:    end_hour_q    <= cfg_data;
					default: ;
				endcase
			end

			if (m_tready && !load_out)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						year_q  <= in_year;
						month_q <= in_month;
						day_q   <= in_day;
						hour_q  <= in_hour;
						need_q  <= sel_eve || sel_start || sel_end;
						// a weekday code of seven means Sunday
						if (sel_start) begin
							rmonth_q <= start_month_q;
							rsel_q   <= start_week_q;
							rwday_q  <= (start_wday_q == 3'd7) ? 3'd0 : start_wday_q;
						end else begin
							rmonth_q <= end_month_q;
							rsel_q   <= end_week_q;
							rwday_q  <= (end_wday_q == 3'd7) ? 3'd0 : end_wday_q;
						end
						state_q <= ST_MULY;
					end
				end
				ST_MULY: begin
					prod_q  <= prod_t'(mul_a * mul_b);
					state_q <= ST_LEAP;
				end
				ST_LEAP: begin
					leap_q  <= leap_now;
					prod_q  <= prod_t'(mul_a * mul_b);
					state_q <= need_q ? ST_SUM : ST_DECIDE;
				end
				ST_SUM: begin
					sum_q   <= wsum;
					state_q <= ST_MUL7;
				end
				ST_MUL7: begin
					prod_q  <= prod_t'(mul_a * mul_b);
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					rday_q  <= 5'd1 + {1'b0, wd_off};
					k_q     <= 3'd1;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					// advance a week until the wanted occurrence or the last in the month
					if (step_done) begin
						state_q <= ST_DECIDE;
					end else begin
						rday_q <= rday_p7[4:0];
						k_q    <= k_q + 3'd1;
						if (k_q == 3'd4)
							state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						act_q       <= on;
						yo_q        <= adj_year;
						mo_q        <= adj_month;
						do_q        <= adj_day;
						ho_q        <= adj_hour;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, ho_q, do_q, mo_q, yo_q, act_q};

	// A transfer starts the sequencer, so the next cycle takes no item
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken twice in a row");

	// Week counter stays within the four possible steps
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (k_q >= 3'd1 && k_q <= 3'd4))
		else $error("week step counter out of range");

	// A found rule day lies within a month
	a_rule_day: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && need_q) |-> (rday_q >= 5'd1 && rday_q <= 5'd31))
		else $error("rule day out of range");

	// Leaving the decide step always presents a result
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && out_free) |=> m_tvalid)
		else $error("result lost at decide");

endmodule
